### sv/bsn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsn_pkg
// Shared types and constants for the BOM strip / newline normalizer.
// ----------------------------------------------------------------------------
package bsn_pkg;

    // Width of the internal line counter. It saturates at all ones.
    localparam int LINE_BITS = 32;
    // Width of the line field in a result.
    localparam int LINE_OUT_W = 32;

    localparam logic [7:0] BOM_1 = 8'hEF;
    localparam logic [7:0] BOM_2 = 8'hBB;
    localparam logic [7:0] BOM_3 = 8'hBF;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [1:0] {
        ST_CHAR   = 2'd0,
        ST_EOF    = 2'd1,
        ST_BADSIG = 2'd2,
        ST_IOERR  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BOM_WAIT1 = 2'd0,
        BOM_WAIT2 = 2'd1,
        BOM_WAIT3 = 2'd2
    } t_bom_phase;

    typedef enum logic [1:0] {
        PAIR_NONE = 2'd0,
        PAIR_CR   = 2'd1,
        PAIR_LF   = 2'd2
    } t_pair;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
        logic       io_fault;
    } t_in_item;

    typedef struct packed {
        t_status               status;
        logic [7:0]            out_byte;
        logic [LINE_OUT_W-1:0] line;
        logic                  bom_flag;
    } t_out_item;

endpackage : bsn_pkg
`default_nettype wire

### sv/bom_strip_newline_normalizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bom_strip_newline_normalizer
// Strips a leading UTF-8 BOM and folds CR, CR+LF, LF+CR into one LF.
// ----------------------------------------------------------------------------
// A taken request waits in the input register until the result slot is free.
// Throughput: one request per cycle while the result slot is free; the core
//   state updates once per byte in a single pass between the input register
//   and the result register. Requests that yield no result (BOM bytes,
//   swallowed pair bytes) still step the core state.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
//   stream state to start of stream, line 1, no terminal status.
// ----------------------------------------------------------------------------
module bom_strip_newline_normalizer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire bsn_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output bsn_pkg::t_out_item      o_out_item
);
    import bsn_pkg::*;

    // input register
    logic      r_in_valid;
    t_in_item  r_in_item;
    // result register
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      out_free;
    logic      fire;
    logic      in_take;
    logic      core_emit;
    t_out_item core_result;

    // The result slot is free when empty or being drained this cycle.
    assign out_free = !r_out_valid || i_out_ready;
    // The held request is processed when its result (if any) has a place.
    assign fire     = r_in_valid && out_free;
    // Input register refills whenever it is empty or moving on.
    assign o_in_ready = !r_in_valid || fire;
    assign in_take    = i_in_valid && o_in_ready;

    bsn_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .o_emit   (core_emit),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && core_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (fire && core_emit) begin
            r_out_item <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule : bom_strip_newline_normalizer
`default_nettype wire

### sv/bsn_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsn_core
// Stream state and per-byte decision logic; state steps on i_fire.
// ----------------------------------------------------------------------------
module bsn_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire bsn_pkg::t_in_item  i_item,
    output logic                    o_emit,
    output bsn_pkg::t_out_item      o_result
);
    import bsn_pkg::*;

    logic                 r_started,  n_started;
    t_bom_phase           r_phase,    n_phase;
    t_pair                r_pair,     n_pair;
    logic                 r_prev_lf,  n_prev_lf;
    logic [LINE_BITS-1:0] r_line,     n_line;
    t_status              r_term,     n_term;
    logic                 r_bom,      n_bom;

    always_comb begin
        logic       go_char;
        logic [7:0] ch;
        t_status    st;

        n_started = r_started;
        n_phase   = r_phase;
        n_pair    = r_pair;
        n_prev_lf = r_prev_lf;
        n_line    = r_line;
        n_term    = r_term;
        n_bom     = r_bom;
        go_char   = 1'b0;
        ch        = i_item.in_byte;
        st        = ST_CHAR;
        o_emit    = 1'b0;

        if (r_term != ST_CHAR) begin
            o_emit = 1'b1;
            st     = r_term;
        end else if (i_item.io_fault) begin
            o_emit = 1'b1;
            st     = ST_IOERR;
        end else if (i_item.end_of_input) begin
            o_emit = 1'b1;
            st     = (!r_started && r_phase != BOM_WAIT1) ? ST_BADSIG : ST_EOF;
        end else if (!r_started) begin
            unique case (r_phase)
                BOM_WAIT1: begin
                    if (i_item.in_byte == BOM_1) begin
                        n_phase = BOM_WAIT2;
                    end else begin
                        n_started = 1'b1;
                        go_char   = 1'b1;
                    end
                end
                BOM_WAIT2: begin
                    if (i_item.in_byte != BOM_2) begin
                        o_emit = 1'b1;
                        st     = ST_BADSIG;
                    end else begin
                        n_phase = BOM_WAIT3;
                    end
                end
                default: begin
                    if (i_item.in_byte != BOM_3) begin
                        o_emit = 1'b1;
                        st     = ST_BADSIG;
                    end else begin
                        n_bom     = 1'b1;
                        n_started = 1'b1;
                    end
                end
            endcase
        end else begin
            go_char = 1'b1;
        end

        if (go_char) begin
            // second byte of a CR+LF or LF+CR pair is swallowed
            if ((r_pair == PAIR_CR && i_item.in_byte == CH_LF) ||
                (r_pair == PAIR_LF && i_item.in_byte == CH_CR)) begin
                n_pair = PAIR_NONE;
            end else begin
                n_pair = PAIR_NONE;
                if (i_item.in_byte == CH_CR) begin
                    n_pair = PAIR_CR;
                    ch     = CH_LF;
                end else if (i_item.in_byte == CH_LF) begin
                    n_pair = PAIR_LF;
                end
                if (r_prev_lf && r_line != {LINE_BITS{1'b1}}) begin
                    n_line = r_line + LINE_BITS'(1);
                end
                n_prev_lf = (ch == CH_LF);
                o_emit    = 1'b1;
            end
        end

        if (o_emit) begin
            n_term = st;
        end

        o_result.status   = st;
        o_result.out_byte = (st == ST_CHAR) ? ch : 8'h00;
        o_result.line     = LINE_OUT_W'(n_line);
        o_result.bom_flag = n_bom;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_phase   <= BOM_WAIT1;
            r_pair    <= PAIR_NONE;
            r_prev_lf <= 1'b0;
            r_line    <= LINE_BITS'(1);
            r_term    <= ST_CHAR;
            r_bom     <= 1'b0;
        end else if (i_fire) begin
            r_started <= n_started;
            r_phase   <= n_phase;
            r_pair    <= n_pair;
            r_prev_lf <= n_prev_lf;
            r_line    <= n_line;
            r_term    <= n_term;
            r_bom     <= n_bom;
        end
    end

endmodule : bsn_core
`default_nettype wire

### sv/bsn_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsn_checker
// Port-level checks for the normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module bsn_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_ready,
    input  wire bsn_pkg::t_out_item o_out_item
);
    import bsn_pkg::*;

    logic out_take;
    assign out_take = o_out_valid && i_out_ready;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // terminal status repeats on the next result
    a_term_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && o_out_item.status != ST_CHAR |=>
            !o_out_valid || o_out_item.status == $past(o_out_item.status))
        else $error("terminal status not sticky");

    // non-character results carry no byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_CHAR |-> o_out_item.out_byte == 8'h00)
        else $error("byte on non-character result");

    // line numbers start at one and never wrap to zero
    a_line_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.line != '0)
        else $error("line number is zero");

    // BOM flag never clears once reported
    a_bom_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && o_out_item.bom_flag |=> !o_out_valid || o_out_item.bom_flag)
        else $error("BOM flag dropped");

endmodule : bsn_checker

bind bom_strip_newline_normalizer bsn_checker u_bsn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
`default_nettype wire
